### design/rtcm_pkg.sv
// Shared types, register offsets and ID table of the seconds counter block.
`default_nettype none

package rtcm_pkg;

    // Item kinds carried on the input tuser.
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } t_opcode;

    // Access widths.
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;

    // Register offsets.
    localparam logic [11:0] OFF_COUNT  = 12'h000;
    localparam logic [11:0] OFF_MATCH  = 12'h004;
    localparam logic [11:0] OFF_LOAD   = 12'h008;
    localparam logic [11:0] OFF_CTRL   = 12'h00C;
    localparam logic [11:0] OFF_MASK   = 12'h010;
    localparam logic [11:0] OFF_RAW    = 12'h014;
    localparam logic [11:0] OFF_MIS    = 12'h018;
    localparam logic [11:0] OFF_CLEAR  = 12'h01C;
    // ID window 0xFE0..0xFFF: top seven offset bits all ones.
    localparam logic [6:0]  ID_PREFIX  = 7'h7F;

    localparam logic [31:0] KEEP_BYTE  = 32'hFFFF_FF00;
    localparam logic [31:0] KEEP_HALF  = 32'hFFFF_0000;

    // One result item.
    typedef struct packed {
        logic        irq_level;
        logic        access_failed;
        logic [31:0] read_value;
    } t_result;

    // Bits of the old value kept by a narrow write.
    function automatic logic [31:0] keep_mask(input logic [1:0] size);
        logic [31:0] m;
        case (size)
            SZ_BYTE: m = KEEP_BYTE;
            SZ_HALF: m = KEEP_HALF;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

    // ID byte table.
    function automatic logic [7:0] id_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h31;
            3'd1:    b = 8'h10;
            3'd2:    b = 8'h14;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'hF0;
            3'd6:    b = 8'h05;
            default: b = 8'hB1;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### design/rtcm_regs.sv
// Register file, counter and alarm logic of the seconds counter block.
`default_nettype none

module rtcm_regs
    import rtcm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic [1:0]  i_op,
    input  wire logic [11:0] i_off,
    input  wire logic [1:0]  i_size,
    input  wire logic [31:0] i_data,
    output t_result          o_result
);

    logic [31:0] r_count, n_count;
    logic [31:0] r_match, n_match;
    logic [31:0] r_load,  n_load;
    logic        r_mask,  n_mask;
    logic        r_raw,   n_raw;
    logic        r_armed, n_armed;

    // Decode the item and work out the next state and its result
    always_comb begin
        logic [31:0] keep;
        logic [31:0] fresh;
        logic [31:0] rd_val;
        logic        hit;
        logic        arm_req;

        n_count  = r_count;
        n_match  = r_match;
        n_load   = r_load;
        n_mask   = r_mask;
        n_raw    = r_raw;
        n_armed  = r_armed;
        keep     = keep_mask(i_size);
        fresh    = i_data & ~keep;
        rd_val   = 32'd0;
        hit      = 1'b1;
        arm_req  = 1'b0;
        o_result.read_value    = 32'd0;
        o_result.access_failed = 1'b0;

        case (t_opcode'(i_op))
            OP_READ: begin
                if (i_off[11:5] == ID_PREFIX) begin
                    rd_val = {24'd0, id_byte(i_off[4:2])};
                end else begin
                    unique case (i_off)
                        OFF_COUNT: rd_val = r_count;
                        OFF_MATCH: rd_val = r_match;
                        OFF_LOAD:  rd_val = r_load;
                        OFF_CTRL:  rd_val = 32'd1;
                        OFF_MASK:  rd_val = {31'd0, r_mask};
                        OFF_RAW:   rd_val = {31'd0, r_raw};
                        OFF_MIS:   rd_val = {31'd0, r_raw & r_mask};
                        default:   hit    = 1'b0;
                    endcase
                end
                if (hit) begin
                    o_result.read_value = rd_val & ~keep;
                end else begin
                    o_result.access_failed = 1'b1;
                end
            end
            OP_WRITE: begin
                unique case (i_off)
                    OFF_LOAD: begin
                        n_count = fresh;
                        n_load  = fresh;
                        arm_req = 1'b1;
                    end
                    OFF_MATCH: begin
                        n_match = (r_match & keep) | fresh;
                        arm_req = 1'b1;
                    end
                    OFF_MASK:  n_mask = fresh[0];
                    OFF_CLEAR: n_raw  = 1'b0;
                    OFF_CTRL:  ;
                    default:   o_result.access_failed = 1'b1;
                endcase
            end
            OP_TICK: begin
                n_count = r_count + 32'd1;
                if (r_armed && (n_count == r_match)) begin
                    n_raw   = 1'b1;
                    n_armed = 1'b0;
                end
            end
            default: ;
        endcase

        // Arm the alarm, or raise the status at once on an existing match
        if (arm_req) begin
            if (n_match == n_count) begin
                n_armed = 1'b0;
                n_raw   = 1'b1;
            end else begin
                n_armed = 1'b1;
            end
        end

        o_result.irq_level = n_raw & n_mask;
    end

    // Hold state; advance it on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 32'd0;
            r_match <= 32'd0;
            r_load  <= 32'd0;
            r_mask  <= 1'b0;
            r_raw   <= 1'b0;
            r_armed <= 1'b0;
        end else if (i_en) begin
            r_count <= n_count;
            r_match <= n_match;
            r_load  <= n_load;
            r_mask  <= n_mask;
            r_raw   <= n_raw;
            r_armed <= n_armed;
        end
    end

endmodule

`default_nettype wire

### design/rtc_seconds_counter_with_match_top.sv
// Top level of the seconds counter with match alarm: stream ports and result register.
// Each accepted item's result is registered and shown on the master side in the next cycle.
// Throughput: one item per cycle; a single result register parts the two sides,
// so a new item is taken whenever the register is empty or is being drained.
// Reset (synchronous, active low) clears counter, match, load, mask, status and
// alarm to zero and empties the result register.
`default_nettype none

module rtc_seconds_counter_with_match_top
    import rtcm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata: reg_offset[11:0], access_size[13:12], write_value[45:14], zero pad
    input  wire logic [47:0] i_s_axis_tdata,
    // tuser: opcode[1:0]
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // tdata: read_value[31:0], access_failed[32], irq_level[33], zero pad
    output logic [39:0]      o_m_axis_tdata
);

    logic    accept;
    t_result result;
    logic    r_out_valid;
    t_result r_out_data;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    rtcm_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept),
        .i_op     (i_s_axis_tuser),
        .i_off    (i_s_axis_tdata[11:0]),
        .i_size   (i_s_axis_tdata[13:12]),
        .i_data   (i_s_axis_tdata[45:14]),
        .o_result (result)
    );

    // Hold the result until the master side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_data.irq_level, r_out_data.access_failed,
                              r_out_data.read_value};

    // Every accepted item shows a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_m_axis_tvalid)
        else $error("accepted item gave no result");

    // A tick never reports a failed access
    a_tick_no_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_axis_tuser == OP_TICK) |=> !o_m_axis_tdata[32])
        else $error("tick reported a failed access");

    // The control register reads back as one at every width
    a_ctrl_reads_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_axis_tuser == OP_READ && i_s_axis_tdata[11:0] == OFF_CTRL)
        |=> (o_m_axis_tdata[32:0] == 33'd1))
        else $error("control register read back wrong");

endmodule

`default_nettype wire
